// File: hw/rtl/integer_sort_engine_assert.svh
// Assertion macros for the integer sort engine.
`ifndef INTEGER_SORT_ENGINE_ASSERT_SVH
`define INTEGER_SORT_ENGINE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Clocked check, off while reset is high.
`define ISE_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds during reset.
`define ISE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ISE_ASSERT(lbl, clk, rst, prop, msg)
`define ISE_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// File: hw/rtl/ise_pkg.sv
// Shared types and constants of the integer sort engine.
package ise_pkg;

   localparam int ValueWidth       = 32;
   localparam int MaxElementsDflt  = 64;

   // Controller states, one-hot.
   typedef enum logic [1:0] {
      ST_LOAD  = 2'b01,
      ST_DRAIN = 2'b10
   } ise_state_type;

   // Commands from controller to datapath.
   typedef struct packed {
      logic insert;      // place the arriving element into the cell row
      logic drop;        // row full: discard the arriving element
      logic close;       // arriving element closes the batch
      logic drain_out;   // load output register from the head cell and shift
      logic drain_skip;  // shift toward the head without output (descending pad)
      logic desc;        // drain direction of the current batch
   } ise_cmd_type;

   // Status from datapath to controller.
   typedef struct packed {
      logic full;        // every cell holds an element
      logic last;        // one element remains
      logic head_ready;  // head cell holds an element of the batch
   } ise_status_type;

endpackage

// File: hw/rtl/integer_sort_engine.sv
// Top level of the integer sort engine: controller, cell-row datapath and checks.
//
// The req channel takes one signed 32-bit element per transaction; req_batch_end
// marks the last element of a batch. Each element is placed into a row of
// MAX_ELEMENTS insertion cells in the cycle it is accepted, so a batch loads at
// one element per cycle. Elements beyond MAX_ELEMENTS are discarded and every
// result of that batch carries rsp_items_dropped.
// After the closing transaction the batch drains on the rsp channel, one
// element per cycle while rsp_stall is low, rsp_final_result on the last one.
// The closing transaction moves the state register to draining, and the head
// cell then goes to the result register; in descending order the row first
// shifts the empty cells past the head. req_stall stays high while a batch
// drains.
// A CSR write stores csr_write_data as the direction (1 descending); a batch
// takes the stored direction at its closing transaction. A high rsp_stall
// holds the result register and pauses the drain; the next batch may load
// while the final result still waits.
// Synchronous reset empties the row, clears the overflow flag, drops any
// pending result and sets ascending order.
module integer_sort_engine #(
   parameter int MAX_ELEMENTS = ise_pkg::MaxElementsDflt
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [ise_pkg::ValueWidth-1:0] req_item_value,
   input  logic                                  req_batch_end,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [ise_pkg::ValueWidth-1:0] rsp_sorted_value,
   output logic                                  rsp_final_result,
   output logic                                  rsp_items_dropped,
   input  logic                                  csr_write_enable,
   input  logic                                  csr_write_data
);
   import ise_pkg::*;

`include "integer_sort_engine_assert.svh"

   ise_cmd_type    dp_cmd;
   ise_status_type dp_status;

   ise_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_batch_end    (req_batch_end),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .cmd              (dp_cmd),
      .status           (dp_status)
   );

   ise_datapath #(
      .MAX_ELEMENTS (MAX_ELEMENTS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (dp_cmd),
      .status            (dp_status),
      .req_item_value    (req_item_value),
      .rsp_sorted_value  (rsp_sorted_value),
      .rsp_final_result  (rsp_final_result),
      .rsp_items_dropped (rsp_items_dropped)
   );

   // Never insert into a full row
   `ISE_ASSERT(a_no_insert_full, clock, reset,
      dp_cmd.insert |-> !dp_status.full, "insert into full row")
   // Row moves one way at a time
   `ISE_ASSERT(a_one_row_op, clock, reset,
      $onehot0({dp_cmd.insert, dp_cmd.drain_out, dp_cmd.drain_skip}),
      "conflicting row operations")
   // Loading the final result reopens the input
   `ISE_ASSERT(a_reopen_after_final, clock, reset,
      (dp_cmd.drain_out && dp_status.last) |=> !req_stall,
      "input not reopened after final result")
   // Reset empties the result register
   `ISE_ASSERT_ALWAYS(a_reset_clears_rsp, clock, reset |=> !rsp_valid,
      "result valid after reset")

endmodule

// File: hw/rtl/ise_datapath.sv
// Insertion cell row, element count, descending pad, overflow flag and result payload registers.
module ise_datapath #(
   parameter int MAX_ELEMENTS = ise_pkg::MaxElementsDflt
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  ise_pkg::ise_cmd_type                  cmd,
   output ise_pkg::ise_status_type               status,
   input  logic signed [ise_pkg::ValueWidth-1:0] req_item_value,
   output logic signed [ise_pkg::ValueWidth-1:0] rsp_sorted_value,
   output logic                                  rsp_final_result,
   output logic                                  rsp_items_dropped
);
   import ise_pkg::*;

   localparam int CountWidth = $clog2(MAX_ELEMENTS + 1);
   localparam logic [CountWidth-1:0] CountMax = CountWidth'(MAX_ELEMENTS);
   localparam logic [CountWidth-1:0] CountOne = CountWidth'(1);

   logic signed [ValueWidth-1:0] cell_ff [MAX_ELEMENTS];
   logic signed [ValueWidth-1:0] cell_in [MAX_ELEMENTS];
   logic [MAX_ELEMENTS-1:0]      bigger;
   logic [CountWidth-1:0]        count_ff, count_in;
   logic [CountWidth-1:0]        pad_ff, pad_in;
   logic                         overflow_ff, overflow_in;
   logic signed [ValueWidth-1:0] value_ff, value_in;
   logic                         final_ff, final_in;
   logic                         dropped_ff, dropped_in;

   // Flag cells that hold no element or a value above the arriving one
   always_comb begin
      for (int i = 0; i < MAX_ELEMENTS; i++) begin
         bigger[i] = (CountWidth'(i) >= count_ff) || (cell_ff[i] > req_item_value);
      end
   end

   // Insert by shifting the greater cells up; drain by shifting toward the head
   always_comb begin
      for (int i = 0; i < MAX_ELEMENTS; i++) begin
         cell_in[i] = cell_ff[i];
      end
      if (cmd.insert) begin
         if (bigger[0]) begin
            cell_in[0] = req_item_value;
         end
         for (int i = 1; i < MAX_ELEMENTS; i++) begin
            if (bigger[i-1]) begin
               cell_in[i] = cell_ff[i-1];
            end else if (bigger[i]) begin
               cell_in[i] = req_item_value;
            end
         end
      end else if ((cmd.drain_out || cmd.drain_skip) && cmd.desc) begin
         for (int i = 1; i < MAX_ELEMENTS; i++) begin
            cell_in[i] = cell_ff[i-1];
         end
      end else if (cmd.drain_out) begin
         for (int i = 0; i < MAX_ELEMENTS - 1; i++) begin
            cell_in[i] = cell_ff[i+1];
         end
      end
   end

   // Track element count, descending pad and overflow
   always_comb begin
      count_in    = count_ff;
      pad_in      = pad_ff;
      overflow_in = overflow_ff;
      if (cmd.insert) begin
         count_in = count_ff + CountOne;
      end else if (cmd.drain_out) begin
         count_in = count_ff - CountOne;
      end
      if (cmd.drop) begin
         overflow_in = 1'b1;
      end else if (cmd.drain_out && status.last) begin
         overflow_in = 1'b0;
      end
      if (cmd.close) begin
         pad_in = CountMax - count_in;
      end else if (cmd.drain_skip) begin
         pad_in = pad_ff - CountOne;
      end
   end

   // Capture the head cell into the result register
   always_comb begin
      value_in   = value_ff;
      final_in   = final_ff;
      dropped_in = dropped_ff;
      if (cmd.drain_out) begin
         value_in   = cmd.desc ? cell_ff[MAX_ELEMENTS-1] : cell_ff[0];
         final_in   = status.last;
         dropped_in = overflow_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_ELEMENTS; i++) begin
         cell_ff[i] <= cell_in[i];
      end
      value_ff   <= value_in;
      final_ff   <= final_in;
      dropped_ff <= dropped_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         pad_ff      <= '0;
         overflow_ff <= 1'b0;
      end else begin
         count_ff    <= count_in;
         pad_ff      <= pad_in;
         overflow_ff <= overflow_in;
      end
   end

   assign status.full       = (count_ff == CountMax);
   assign status.last       = (count_ff == CountOne);
   assign status.head_ready = !cmd.desc || (pad_ff == '0);

   assign rsp_sorted_value  = value_ff;
   assign rsp_final_result  = final_ff;
   assign rsp_items_dropped = dropped_ff;

endmodule

// File: hw/rtl/ise_ctrl.sv
// Controller: load and drain state machine, direction register and result valid.
module ise_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic                    req_batch_end,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  logic                    csr_write_enable,
   input  logic                    csr_write_data,
   output ise_pkg::ise_cmd_type    cmd,
   input  ise_pkg::ise_status_type status
);
   import ise_pkg::*;

   ise_state_type state_ff, state_in;
   logic          csr_desc_ff, csr_desc_in;
   logic          dir_ff, dir_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          accept;
   logic          slot_free;

   assign req_stall = (state_ff != ST_LOAD);
   assign accept    = req_valid && !req_stall;
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   // Write the CSR direction register; sample it into the batch direction when the batch closes
   always_comb begin
      csr_desc_in = csr_write_enable ? csr_write_data : csr_desc_ff;
      dir_in      = (accept && req_batch_end) ? csr_desc_ff : dir_ff;
   end

   // Decode datapath commands from state and handshakes
   always_comb begin
      cmd            = '0;
      cmd.desc       = dir_ff;
      cmd.insert     = accept && !status.full;
      cmd.drop       = accept && status.full;
      cmd.close      = accept && req_batch_end;
      if (state_ff == ST_DRAIN) begin
         cmd.drain_out  = status.head_ready && slot_free;
         cmd.drain_skip = !status.head_ready;
      end
   end

   // Advance between loading and draining
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD: begin
            if (cmd.close) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (cmd.drain_out && status.last) begin
               state_in = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // Keep the result valid until the receiver takes it
   always_comb begin
      if (cmd.drain_out) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         csr_desc_ff  <= 1'b0;
         dir_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         csr_desc_ff  <= csr_desc_in;
         dir_ff       <= dir_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
